// ----- src/i2r_pkg.sv -----
package i2r_pkg;

  localparam int ValueWidth  = 12;
  localparam int SymWidth    = 8;
  localparam int NumSyms     = 13;
  localparam int IdxWidth    = $clog2(NumSyms);
  localparam int SymValWidth = 10;
  localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

  localparam logic [SymWidth-1:0] CharNone = 8'h00;
  localparam logic [SymWidth-1:0] CharI    = 8'h49;
  localparam logic [SymWidth-1:0] CharV    = 8'h56;
  localparam logic [SymWidth-1:0] CharX    = 8'h58;
  localparam logic [SymWidth-1:0] CharL    = 8'h4C;
  localparam logic [SymWidth-1:0] CharC    = 8'h43;
  localparam logic [SymWidth-1:0] CharD    = 8'h44;
  localparam logic [SymWidth-1:0] CharM    = 8'h4D;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new value
    logic step;   // emit one letter or move to the next symbol
    logic fault;  // emit the single error result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;  // value port holds 1..3999
    logic fin;       // this step emits the final letter
  } stat_t;

  function automatic logic [SymValWidth-1:0] sym_val(input logic [IdxWidth-1:0] idx);
    logic [SymValWidth-1:0] v;
    case (idx)
      4'd0:    v = 10'd1000;
      4'd1:    v = 10'd900;
      4'd2:    v = 10'd500;
      4'd3:    v = 10'd400;
      4'd4:    v = 10'd100;
      4'd5:    v = 10'd90;
      4'd6:    v = 10'd50;
      4'd7:    v = 10'd40;
      4'd8:    v = 10'd10;
      4'd9:    v = 10'd9;
      4'd10:   v = 10'd5;
      4'd11:   v = 10'd4;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

  function automatic logic [SymWidth-1:0] sym_first(input logic [IdxWidth-1:0] idx);
    logic [SymWidth-1:0] c;
    case (idx)
      4'd0:    c = CharM;
      4'd1:    c = CharC;
      4'd2:    c = CharD;
      4'd3:    c = CharC;
      4'd4:    c = CharC;
      4'd5:    c = CharX;
      4'd6:    c = CharL;
      4'd7:    c = CharX;
      4'd8:    c = CharX;
      4'd9:    c = CharI;
      4'd10:   c = CharV;
      4'd11:   c = CharI;
      default: c = CharI;
    endcase
    return c;
  endfunction

  // CharNone means the symbol is a single letter
  function automatic logic [SymWidth-1:0] sym_second(input logic [IdxWidth-1:0] idx);
    logic [SymWidth-1:0] c;
    case (idx)
      4'd1:    c = CharM;
      4'd3:    c = CharD;
      4'd5:    c = CharC;
      4'd7:    c = CharL;
      4'd9:    c = CharX;
      4'd11:   c = CharV;
      default: c = CharNone;
    endcase
    return c;
  endfunction

endpackage

// ----- src/integer_to_roman_numeral.sv -----
// Integer to Roman numeral converter.
//
// Input: pulse start with a 12-bit value while busy is low; the transaction
// is taken at that clock edge and busy rises on the next cycle.
// Output: one transaction per letter, most significant first. Each letter
// shows on symbol (ASCII) for exactly one cycle with strobe high; last marks
// the final letter of the numeral. The receiver cannot stall the output.
// Values 0 and 4000..4095 give a single transaction with symbol 0, last and
// error set, emitted from the fault state through the result registers.
// The first letter comes from the run state through the result registers.
// The controller walks the 13-entry symbol table once; each step emits one
// letter or moves past one table entry, so 3888 takes the most steps (15
// letters plus 12 steps past entries). The walk over the table in the
// datapath sets the length of a conversion.
// A new value may be started in the cycle that carries the final letter.
// Reset (rst, synchronous) returns the controller to idle and drops strobe.
module integer_to_roman_numeral (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [i2r_pkg::ValueWidth-1:0]  value,
  output logic                            strobe,
  output logic [i2r_pkg::SymWidth-1:0]    symbol,
  output logic                            last,
  output logic                            error
);

  i2r_pkg::cmd_t  cmd;
  i2r_pkg::stat_t stat;

  // Sequence control: idle, run the table walk, or emit the error result
  i2r_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Remainder, table index, pending second letter and result registers
  i2r_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .value  (value),
    .strobe (strobe),
    .symbol (symbol),
    .last   (last),
    .error  (error)
  );

endmodule

// ----- src/i2r_datapath.sv -----
module i2r_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  i2r_pkg::cmd_t                    cmd,
  output i2r_pkg::stat_t                   stat,
  input  logic [i2r_pkg::ValueWidth-1:0]   value,
  output logic                             strobe,
  output logic [i2r_pkg::SymWidth-1:0]     symbol,
  output logic                             last,
  output logic                             error
);

  logic [i2r_pkg::ValueWidth-1:0]  rest;
  logic [i2r_pkg::IdxWidth-1:0]    idx;
  logic                            second;

  logic [i2r_pkg::ValueWidth-1:0]  cur_val;
  logic [i2r_pkg::ValueWidth-1:0]  rest_sub;
  logic [i2r_pkg::SymWidth-1:0]    second_char;
  logic                            ge;
  logic                            advance;

  assign cur_val     = {{(i2r_pkg::ValueWidth-i2r_pkg::SymValWidth){1'b0}}, i2r_pkg::sym_val(idx)};
  assign ge          = (rest >= cur_val);
  assign rest_sub    = rest - cur_val;
  assign second_char = i2r_pkg::sym_second(idx);
  assign advance     = !second && !ge;

  assign stat.in_range = (value != '0) && (value <= i2r_pkg::MaxValue);
  assign stat.fin      = second ? (rest == '0)
                                : (ge && (rest_sub == '0) && (second_char == i2r_pkg::CharNone));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest   <= value;
      idx    <= '0;
      second <= 1'b0;
    end else if (cmd.step) begin
      if (second) begin
        second <= 1'b0;
      end else if (ge) begin
        rest   <= rest_sub;
        second <= (second_char != i2r_pkg::CharNone);
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.fault || (cmd.step && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fault) begin
      symbol <= i2r_pkg::CharNone;
      last   <= 1'b1;
      error  <= 1'b1;
    end else begin
      symbol <= second ? second_char : i2r_pkg::sym_first(idx);
      last   <= stat.fin;
      error  <= 1'b0;
    end
  end

endmodule

// ----- src/i2r_ctrl.sv -----
module i2r_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  i2r_pkg::stat_t  stat,
  output i2r_pkg::cmd_t   cmd
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StFault = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      StIdle: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.in_range ? StRun : StFault;
        end
      end
      StRun: begin
        cmd.step = 1'b1;
        if (stat.fin) begin
          state_next = StIdle;
        end
      end
      StFault: begin
        cmd.fault  = 1'b1;
        state_next = StIdle;
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != StIdle);

endmodule

// ----- src/i2r_checker.sv -----
module i2r_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            strobe,
  input logic [i2r_pkg::SymWidth-1:0]    symbol,
  input logic                            last,
  input logic                            error
);

  // An error result is always a lone, final, empty transaction
  assert property (@(posedge clk) disable iff (rst)
    strobe && error |-> last && (symbol == i2r_pkg::CharNone))
    else $error("error result malformed");

  // Valid results carry a numeral letter
  assert property (@(posedge clk) disable iff (rst)
    strobe && !error |-> (symbol == i2r_pkg::CharI) || (symbol == i2r_pkg::CharV) ||
      (symbol == i2r_pkg::CharX) || (symbol == i2r_pkg::CharL) ||
      (symbol == i2r_pkg::CharC) || (symbol == i2r_pkg::CharD) ||
      (symbol == i2r_pkg::CharM))
    else $error("bad letter");

  // The cycle after a final letter is never another result
  assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result after last");

  // An accepted value makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .symbol (symbol),
  .last   (last),
  .error  (error)
);
